[sv/cbpg_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Cubic Bezier point generator: shared definitions
// Widths, register indexes, request codes and the controller/datapath
// command and status structures.
// ============================================================================
package cbpg_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 20;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int CFG_DATA_BITS  = 60;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_CTRL_PTS   = 4;
    localparam int NUM_AXES       = 3;
    localparam int NUM_LANES      = 3;
    localparam int LERP_STAGES    = 3;
    localparam int IDX_BITS       = 6;
    localparam int COUNT_BITS     = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CTRL_POINT_0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CTRL_POINT_1 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CTRL_POINT_2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CTRL_POINT_3 = 3'd3;

    localparam logic REQ_SINGLE = 1'b0;
    localparam logic REQ_RUN    = 1'b1;

    typedef struct packed {
        logic                set_single;
        logic                div_start;
        logic                run_init;
        logic                load_pts;
        logic                mul;
        logic                add;
        logic                out_load;
        logic                step_t;
        logic [IDX_BITS-1:0] span;
        logic [IDX_BITS-1:0] index;
        logic                last;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

[sv/cbpg_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// Cubic Bezier point generator: step divider
// Restoring divider that forms 2^T_FRAC_BITS / span one quotient bit a cycle.
// ============================================================================
module cbpg_div
    import cbpg_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [IDX_BITS-1:0]    i_divisor,
    output logic                   o_done,
    output logic [T_FRAC_BITS:0]   o_quotient,
    output logic [IDX_BITS-1:0]    o_remainder
);

    localparam int CNT_BITS = $clog2(T_FRAC_BITS + 2);
    localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(T_FRAC_BITS + 1);

    logic                r_busy;
    logic [CNT_BITS-1:0] r_cnt;
    logic [T_FRAC_BITS:0] r_quo;
    logic [IDX_BITS-1:0] r_rem;
    logic [IDX_BITS-1:0] r_div;

    logic [IDX_BITS:0]   w_part;
    logic [IDX_BITS+1:0] w_trial;

    // The next dividend bit is shifted out of the top of the quotient register.
    assign w_part  = {r_rem, r_quo[T_FRAC_BITS]};
    assign w_trial = {1'b0, w_part} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEPS;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {1'b1, {T_FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            if (!w_trial[IDX_BITS+1]) begin
                r_rem <= w_trial[IDX_BITS-1:0];
                r_quo <= {r_quo[T_FRAC_BITS-1:0], 1'b1};
            end else begin
                r_rem <= w_part[IDX_BITS-1:0];
                r_quo <= {r_quo[T_FRAC_BITS-1:0], 1'b0};
            end
        end
    end

    assign o_done      = r_busy && (r_cnt == '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[sv/cbpg_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// Cubic Bezier point generator: datapath
// Control point registers, parameter stepper, de Casteljau lanes for the
// three axes and the output register.
// ============================================================================
module cbpg_datapath
    import cbpg_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic [T_FRAC_BITS:0]         i_curve_param,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic signed [COORD_BITS-1:0] o_coord_x,
    output logic signed [COORD_BITS-1:0] o_coord_y,
    output logic signed [COORD_BITS-1:0] o_coord_z,
    output logic [IDX_BITS-1:0]          o_point_index,
    output logic                         o_last_point
);

    localparam int EXT_W = (NUM_AXES * COORD_BITS > CFG_DATA_BITS) ?
                           NUM_AXES * COORD_BITS : CFG_DATA_BITS;
    localparam int PW    = COORD_BITS + T_FRAC_BITS + 3;
    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic signed [PW-1:0] HALF  = PW'(1) << (T_FRAC_BITS - 1);

    logic [CFG_DATA_BITS-1:0]     r_ctrl_pt [NUM_CTRL_PTS];
    logic signed [COORD_BITS-1:0] r_pt      [NUM_AXES][NUM_CTRL_PTS];
    logic signed [PW-1:0]         r_prod    [NUM_AXES][NUM_LANES];
    logic [T_FRAC_BITS:0]         r_t;
    logic [IDX_BITS-1:0]          r_r;
    logic [IDX_BITS-1:0]          r_span;

    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_out_x;
    logic signed [COORD_BITS-1:0] r_out_y;
    logic signed [COORD_BITS-1:0] r_out_z;
    logic [IDX_BITS-1:0]          r_out_index;
    logic                         r_out_last;

    logic                         w_div_done;
    logic [T_FRAC_BITS:0]         w_q0;
    logic [IDX_BITS-1:0]          w_r0;
    logic [IDX_BITS:0]            w_rsum;
    logic [EXT_W-1:0]             w_ext     [NUM_CTRL_PTS];
    logic signed [COORD_BITS-1:0] w_init    [NUM_AXES][NUM_CTRL_PTS];
    logic signed [PW-1:0]         w_mul     [NUM_AXES][NUM_LANES];
    logic signed [COORD_BITS-1:0] w_lerp    [NUM_AXES][NUM_LANES];
    logic signed [PW-1:0]         w_rnd     [NUM_AXES][NUM_LANES];

    cbpg_div #(
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (i_cmd.span),
        .o_done     (w_div_done),
        .o_quotient (w_q0),
        .o_remainder(w_r0)
    );

    // Control point registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CTRL_PTS; i++) begin
                r_ctrl_pt[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CTRL_POINT_0: r_ctrl_pt[0] <= i_cfg_data;
                CFG_CTRL_POINT_1: r_ctrl_pt[1] <= i_cfg_data;
                CFG_CTRL_POINT_2: r_ctrl_pt[2] <= i_cfg_data;
                CFG_CTRL_POINT_3: r_ctrl_pt[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Coordinate fields that lie beyond the register read as zero.
    always_comb begin
        for (int i = 0; i < NUM_CTRL_PTS; i++) begin
            w_ext[i] = EXT_W'(r_ctrl_pt[i]);
            for (int a = 0; a < NUM_AXES; a++) begin
                w_init[a][i] = w_ext[i][a*COORD_BITS +: COORD_BITS];
            end
        end
    end

    // Each lane forms a + round(t * (b - a) / 2^T_FRAC_BITS), which equals
    // the rounded blend (u*a + t*b) / 2^T_FRAC_BITS.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                w_mul[a][i] = PW'(($signed({r_pt[a][i+1][COORD_BITS-1], r_pt[a][i+1]})
                                 - $signed({r_pt[a][i][COORD_BITS-1], r_pt[a][i]}))
                                 * $signed({1'b0, r_t}));
                w_rnd[a][i]  = (r_prod[a][i] + HALF) >>> T_FRAC_BITS;
                w_lerp[a][i] = r_pt[a][i] + w_rnd[a][i][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pts) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int i = 0; i < NUM_CTRL_PTS; i++) begin
                    r_pt[a][i] <= w_init[a][i];
                end
            end
        end else if (i_cmd.add) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    r_pt[a][i] <= w_lerp[a][i];
                end
            end
        end
        if (i_cmd.mul) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    r_prod[a][i] <= w_mul[a][i];
                end
            end
        end
    end

    // Run parameters advance by quotient and remainder of 2^T_FRAC_BITS / span,
    // so that t always equals the rounded k * 2^T_FRAC_BITS / span.
    assign w_rsum = {1'b0, r_r} + {1'b0, w_r0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_single) begin
            r_t <= (i_curve_param > T_ONE) ? T_ONE : i_curve_param;
        end else if (i_cmd.run_init) begin
            r_t <= '0;
            r_r <= r_span >> 1;
        end else if (i_cmd.step_t) begin
            if (w_rsum >= {1'b0, r_span}) begin
                r_t <= r_t + w_q0 + 1'b1;
                r_r <= IDX_BITS'(w_rsum - {1'b0, r_span});
            end else begin
                r_t <= r_t + w_q0;
                r_r <= w_rsum[IDX_BITS-1:0];
            end
        end
        if (i_cmd.div_start) begin
            r_span <= i_cmd.span;
        end
    end

    // Output register: a finished point waits here while the next is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x     <= r_pt[0][0];
            r_out_y     <= r_pt[1][0];
            r_out_z     <= r_pt[2][0];
            r_out_index <= i_cmd.index;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_coord_x     = r_out_x;
    assign o_coord_y     = r_out_y;
    assign o_coord_z     = r_out_z;
    assign o_point_index = r_out_index;
    assign o_last_point  = r_out_last;

endmodule

[sv/cbpg_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// Cubic Bezier point generator: controller
// Sequences request intake, step division, the three subdivision stages of
// each point and the transfer of each point to the output register.
// ============================================================================
module cbpg_ctrl
    import cbpg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [COUNT_BITS-1:0] i_point_count,
    input  t_dp_status            i_status,
    output t_dp_cmd               o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_POINTS);
    localparam logic [1:0]            LAST_STAGE = 2'(LERP_STAGES - 1);

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [1:0]            r_stage;
    logic [1:0]            n_stage;
    logic [IDX_BITS-1:0]   r_k;
    logic [IDX_BITS-1:0]   n_k;
    logic [IDX_BITS-1:0]   r_span;
    logic [IDX_BITS-1:0]   n_span;
    logic                  r_single;
    logic                  n_single;

    logic [COUNT_BITS-1:0] w_count;
    logic [IDX_BITS-1:0]   w_span;
    logic                  w_accept;
    logic                  w_last;

    always_comb begin
        if (i_point_count < MIN_COUNT) begin
            w_count = MIN_COUNT;
        end else if (i_point_count > MAX_COUNT) begin
            w_count = MAX_COUNT;
        end else begin
            w_count = i_point_count;
        end
    end

    assign w_span     = IDX_BITS'(w_count - 1'b1);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_last     = r_single || (r_k == r_span);

    always_comb begin
        n_state  = r_state;
        n_stage  = r_stage;
        n_k      = r_k;
        n_span   = r_span;
        n_single = r_single;
        o_cmd            = '0;
        o_cmd.span       = w_span;
        o_cmd.index      = r_k;
        o_cmd.last       = w_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_k = '0;
                    if (i_req_type == REQ_RUN) begin
                        n_single        = 1'b0;
                        n_span          = w_span;
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end else begin
                        n_single         = 1'b1;
                        o_cmd.set_single = 1'b1;
                        n_state          = ST_LOAD;
                    end
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.run_init = 1'b1;
                    n_state        = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_pts = 1'b1;
                n_stage        = '0;
                n_state        = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                if (r_stage == LAST_STAGE) begin
                    n_state = ST_OUT;
                end else begin
                    n_stage = r_stage + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.step_t = 1'b1;
                        n_k          = r_k + 1'b1;
                        n_state      = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_stage  <= '0;
            r_k      <= '0;
            r_span   <= '0;
            r_single <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_stage  <= n_stage;
            r_k      <= n_k;
            r_span   <= n_span;
            r_single <= n_single;
        end
    end

endmodule

[sv/cubic_bezier_point_generator_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// Cubic Bezier point generator unit
// Evaluates a 3-D cubic Bezier curve from four control points written over the
// configuration port (x, y, z packed low to high, signed Q12.8). A request asks
// either for one point at t = i_curve_param (values above 1.0 saturate) or for
// a run of N evenly spaced points with N clamped to 2..MAX_POINTS; the final
// point of every request carries o_last_point. Each point is built in order:
// the control points are loaded, three de Casteljau stages each do a multiply
// step and then an add step across nine parallel lanes, and the point is moved
// into the output register once that register is free. A run first derives
// the parameter step in the serial divider. A new request is taken once the
// last point of the previous one has been placed in the output register.
// ============================================================================
module cubic_bezier_point_generator_unit
    import cbpg_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [T_FRAC_BITS:0]         i_curve_param,
    input  logic [COUNT_BITS-1:0]        i_point_count,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_coord_x,
    output logic signed [COORD_BITS-1:0] o_coord_y,
    output logic signed [COORD_BITS-1:0] o_coord_z,
    output logic [IDX_BITS-1:0]          o_point_index,
    output logic                         o_last_point
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    cbpg_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_point_count(i_point_count),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    cbpg_datapath #(
        .COORD_BITS (COORD_BITS),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_curve_param(i_curve_param),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_coord_x    (o_coord_x),
        .o_coord_y    (o_coord_y),
        .o_coord_z    (o_coord_z),
        .o_point_index(o_point_index),
        .o_last_point (o_last_point)
    );

endmodule
